// ===== rtl/core/websocket_frame_parser_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef WEBSOCKET_FRAME_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define WSFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define WSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/wsfp_pkg.sv =====
// types and constants of the websocket frame parser
// no dependencies
package wsfp_pkg;

   localparam int LENGTH_BITS = 32;
   localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;
   localparam logic [31:0] MAX_MESSAGE_RESET = 32'd1048576;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [0:0] CSR_MAX_FRAME = 1'b0;
   localparam logic [0:0] CSR_MAX_MESSAGE = 1'b1;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_RESERVED = 3'd1;
   localparam logic [2:0] ERR_FRAME_LONG = 3'd2;
   localparam logic [2:0] ERR_FRAG_CTRL = 3'd3;
   localparam logic [2:0] ERR_SEQUENCE = 3'd4;
   localparam logic [2:0] ERR_MSG_LONG = 3'd5;

   localparam logic [3:0] OP_CONT = 4'd0;
   localparam logic [3:0] OP_CLOSE = 4'd8;
   localparam logic [3:0] OP_PING = 4'd9;
   localparam logic [3:0] OP_PONG = 4'd10;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic [3:0] frame_opcode;
      logic       fin_flag;
      logic       masked;
      logic       is_control;
      logic [3:0] msg_opcode;
      logic       end_of_frame;
      logic       end_of_message;
      logic [2:0] error_code;
   } result_type;

   function automatic logic is_ctrl(input logic [3:0] op);
      is_ctrl = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
   endfunction

endpackage

// ===== rtl/core/wsfp_front.sv =====
// front end: header parsing, length and sequence checks, unmasking; one result per byte at most
// depends on wsfp_pkg
module wsfp_front import wsfp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       in_byte,
   input  logic [31:0]      max_frame,
   input  logic [31:0]      max_message,
   output logic             emit,
   output result_type       result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  hidx_ff, hidx_in;
   logic [3:0]  op_ff, op_in;
   logic        fin_ff, fin_in;
   logic        msk_ff, msk_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  kpos_ff, kpos_in;
   logic        open_ff, open_in;
   logic [3:0]  mop_ff, mop_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         hidx_ff  <= '0;
         op_ff    <= '0;
         fin_ff   <= 1'b0;
         msk_ff   <= 1'b0;
         rem_ff   <= '0;
         key_ff   <= '0;
         kpos_ff  <= '0;
         open_ff  <= 1'b0;
         mop_ff   <= '0;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         op_ff    <= op_in;
         fin_ff   <= fin_in;
         msk_ff   <= msk_in;
         rem_ff   <= rem_in;
         key_ff   <= key_in;
         kpos_ff  <= kpos_in;
         open_ff  <= open_in;
         mop_ff   <= mop_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      logic        do_acc;
      logic        do_start;
      logic        do_finish;
      logic [31:0] len_v;
      logic [31:0] len_m;
      logic [32:0] msg_sum;
      logic [7:0]  kb;
      logic [7:0]  data;
      logic        has;
      logic [2:0]  err;
      logic        ctrl;
      logic        eom;
      do_acc    = 1'b0;
      do_start  = 1'b0;
      do_finish = 1'b0;
      len_v     = '0;
      len_m     = '0;
      msg_sum   = '0;
      kb        = '0;
      data      = '0;
      has       = 1'b0;
      err       = ERR_NONE;
      ctrl      = 1'b0;
      eom       = 1'b0;
      phase_in  = phase_ff;
      hidx_in   = hidx_ff;
      op_in     = op_ff;
      fin_in    = fin_ff;
      msk_in    = msk_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      kpos_in   = kpos_ff;
      open_in   = open_ff;
      mop_in    = mop_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      emit      = 1'b0;

      if (!err_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               op_in  = in_byte[3:0];
               fin_in = in_byte[7];
               msk_in = 1'b0;
               if (in_byte[6:4] != 3'd0) begin
                  err = ERR_RESERVED;
               end else begin
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               msk_in  = in_byte[7];
               hidx_in = '0;
               rem_in  = '0;
               if (in_byte[6:0] == 7'd126) begin
                  phase_in = PH_EXT16;
               end else if (in_byte[6:0] == 7'd127) begin
                  phase_in = PH_EXT64;
               end else begin
                  len_v  = {25'd0, in_byte[6:0]};
                  do_acc = 1'b1;
               end
            end
            PH_EXT16: begin
               rem_in  = {rem_ff[23:0], in_byte};
               hidx_in = hidx_ff + 4'd1;
               len_v   = rem_in;
               do_acc  = (hidx_in >= 4'd2);
            end
            PH_EXT64: begin
               if (hidx_ff >= 4'd4) begin
                  rem_in = {rem_ff[23:0], in_byte};
               end
               hidx_in = hidx_ff + 4'd1;
               len_v   = rem_in;
               do_acc  = (hidx_in >= 4'd8);
            end
            PH_KEY: begin
               key_in   = {key_ff[23:0], in_byte};
               hidx_in  = hidx_ff + 4'd1;
               do_start = (hidx_in >= 4'd4);
            end
            PH_PAYLOAD: begin
               if (msk_ff) begin
                  case (kpos_ff)
                     2'd0:    kb = key_ff[31:24];
                     2'd1:    kb = key_ff[23:16];
                     2'd2:    kb = key_ff[15:8];
                     default: kb = key_ff[7:0];
                  endcase
               end
               kpos_in = kpos_ff + 2'd1;
               rem_in  = rem_ff - 32'd1;
               data    = in_byte ^ kb;
               has     = 1'b1;
               if (rem_in == 32'd0) begin
                  do_finish = 1'b1;
               end else begin
                  emit = 1'b1;
               end
            end
            default: phase_in = PH_HDR0;
         endcase

         // header complete: limit and sequence checks on the final length
         if (do_acc) begin
            ctrl    = is_ctrl(op_in);
            len_m   = len_v & LEN_MASK;
            rem_in  = len_m;
            msg_sum = {1'b0, cnt_ff} + {1'b0, len_m};
            if (len_m > max_frame) begin
               err = ERR_FRAME_LONG;
            end else if (ctrl && !fin_in) begin
               err = ERR_FRAG_CTRL;
            end else if (!ctrl && (open_ff != (op_in == OP_CONT))) begin
               err = ERR_SEQUENCE;
            end else if (!ctrl && (msg_sum > {1'b0, max_message})) begin
               err = ERR_MSG_LONG;
            end else begin
               if (!ctrl) begin
                  if (!open_ff) begin
                     open_in = 1'b1;
                     mop_in  = op_in;
                  end
                  cnt_in = msg_sum[31:0];
               end
               hidx_in = '0;
               if (msk_in) begin
                  key_in   = '0;
                  phase_in = PH_KEY;
               end else begin
                  do_start = 1'b1;
               end
            end
         end

         if (do_start) begin
            kpos_in = '0;
            if (rem_in == 32'd0) begin
               do_finish = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         if (do_finish) begin
            eom      = !is_ctrl(op_in) && fin_in;
            emit     = 1'b1;
            phase_in = PH_HDR0;
         end

         if (err != ERR_NONE) begin
            err_in = 1'b1;
            emit   = 1'b1;
         end
      end

      result.data_byte      = data;
      result.has_data       = has;
      result.frame_opcode   = op_in;
      result.fin_flag       = fin_in;
      result.masked         = msk_in;
      result.is_control     = is_ctrl(op_in);
      result.msg_opcode     = open_in ? mop_in : 4'd0;
      result.end_of_frame   = do_finish;
      result.end_of_message = eom;
      result.error_code     = err;

      // a completed message closes after its last result is formed
      if (eom) begin
         open_in = 1'b0;
         cnt_in  = '0;
      end
   end

endmodule

// ===== rtl/core/wsfp_queue.sv =====
// result queue between the parser and the output channel
// depends on wsfp_pkg
module wsfp_queue import wsfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   result_type            store_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, wr_in;
   logic [PTR_BITS-1:0]   rd_ff, rd_in;
   logic [PTR_BITS:0]     cnt_ff, cnt_in;
   logic                  pop;

   assign full      = (cnt_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = store_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/websocket_frame_parser.sv =====
// Websocket frame parser: takes one received byte per cycle while req_ready is high and
// returns at most one result per byte. The parser decides each byte in the cycle it is
// accepted and writes its result into a two-entry result queue on that transfer; the queue
// decouples rsp_ready, and req_ready drops only while that queue is full. After any
// protocol error the block keeps taking bytes but sends nothing until reset.
module websocket_frame_parser import wsfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_has_data,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_fin_flag,
   output logic        rsp_masked,
   output logic        rsp_is_control,
   output logic [3:0]  rsp_msg_opcode,
   output logic        rsp_end_of_frame,
   output logic        rsp_end_of_message,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] max_frame_ff;
   logic [31:0] max_message_ff;
   logic        step;
   logic        emit;
   logic        full;
   result_type  front_res;
   result_type  out_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff   <= MAX_FRAME_RESET;
         max_message_ff <= MAX_MESSAGE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_FRAME:   max_frame_ff   <= csr_wdata;
            CSR_MAX_MESSAGE: max_message_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !full;
   assign step      = req_valid && req_ready;

   wsfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .in_byte     (req_in_byte),
      .max_frame   (max_frame_ff),
      .max_message (max_message_ff),
      .emit        (emit),
      .result      (front_res)
   );

   wsfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step && emit),
      .push_data (front_res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_res)
   );

   assign rsp_data_byte      = out_res.data_byte;
   assign rsp_has_data       = out_res.has_data;
   assign rsp_frame_opcode   = out_res.frame_opcode;
   assign rsp_fin_flag       = out_res.fin_flag;
   assign rsp_masked         = out_res.masked;
   assign rsp_is_control     = out_res.is_control;
   assign rsp_msg_opcode     = out_res.msg_opcode;
   assign rsp_end_of_frame   = out_res.end_of_frame;
   assign rsp_end_of_message = out_res.end_of_message;
   assign rsp_error_code     = out_res.error_code;

endmodule

// ===== rtl/core/wsfp_checker.sv =====
// port-level checks on the websocket frame parser result channel
// depends on websocket_frame_parser_macros.svh and wsfp_pkg
`include "websocket_frame_parser_macros.svh"
module wsfp_checker import wsfp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_has_data,
   input logic       rsp_is_control,
   input logic       rsp_end_of_frame,
   input logic       rsp_end_of_message,
   input logic [2:0] rsp_error_code
);

   `WSFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `WSFP_ASSERT_IMPL(a_no_data_zero, clock, reset, rsp_valid && !rsp_has_data, rsp_data_byte == 8'd0)
   `WSFP_ASSERT_IMPL(a_err_bare, clock, reset, rsp_valid && (rsp_error_code != ERR_NONE), !rsp_has_data && !rsp_end_of_frame)
   `WSFP_ASSERT_IMPL(a_eom_eof, clock, reset, rsp_valid && rsp_end_of_message, rsp_end_of_frame && !rsp_is_control)

endmodule

bind websocket_frame_parser wsfp_checker u_wsfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_has_data       (rsp_has_data),
   .rsp_is_control     (rsp_is_control),
   .rsp_end_of_frame   (rsp_end_of_frame),
   .rsp_end_of_message (rsp_end_of_message),
   .rsp_error_code     (rsp_error_code)
);
